/* rtl/mfp_pkg.sv */
// Package for the MSB-first field packer: word types, function codes and
// stream counter sizing. No dependencies.
package mfp_pkg;

  localparam int unsigned STREAM_BYTES = 1024;
  localparam int unsigned CNT_W        = $clog2(STREAM_BYTES);
  localparam int unsigned OFFSET_W     = 10;

  typedef enum logic [1:0] {
    FUNC_PLAIN    = 2'd0,
    FUNC_SIGN_MAG = 2'd1,
    FUNC_CHECKED  = 2'd2,
    FUNC_FLUSH    = 2'd3
  } mfp_func_e;

  typedef struct packed {
    mfp_func_e          func;
    logic [6:0]         field_width;
    logic signed [63:0] field_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic                byte_valid;
    logic [OFFSET_W-1:0] byte_offset;
    logic                range_error;
    logic                last_of_run;
  } out_word_t;

  // Encoded field: bits left-aligned in a 64-bit word, len of them valid.
  typedef struct packed {
    logic        flush;
    logic [63:0] bits;
    logic [6:0]  len;
    logic        err;
  } enc_t;

  // A run of completed bytes from one item, earliest byte in the top lane.
  typedef struct packed {
    logic [63:0]      bytes;
    logic [3:0]       nbytes;
    logic [CNT_W-1:0] base;
    logic             err;
  } run_t;

endpackage

/* rtl/msb_first_field_packer_top.sv */
// Top level of the MSB-first field packer: encoder, packing state and
// result register. Depends on mfp_pkg, mfp_encode, mfp_pack and mfp_emit.
//
//   Channel  Handshake               Word
//   in       in_valid_i/in_stall_o   in_word_t  (func, field_width, field_value)
//   out      out_valid_o/out_stall_i out_word_t (at most one stream byte per word)
//
// An item passes an input register and an encoder register, then merges with
// the partial byte as it enters the result register. It leaves as max(1,
// completed bytes) words, 1 to 8 per item, one per cycle while out_stall_i is
// low, so the output port sets the rate. Reset clears the valid bits, the
// partial byte, the bit fill and the byte counter. out_stall_i backs up the
// stages in order and reaches in_stall_o once all of them hold a word.
module msb_first_field_packer_top import mfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic in_ready;
  logic enc_valid;
  logic run_ready;
  enc_t enc;
  run_t run;

  mfp_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word_i),
    .enc_valid_o (enc_valid),
    .enc_ready_i (run_ready),
    .enc_o       (enc)
  );

  mfp_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (enc_valid && run_ready),
    .enc_i  (enc),
    .run_o  (run)
  );

  mfp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (enc_valid),
    .run_ready_o (run_ready),
    .run_i       (run),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign in_stall_o = !in_ready;

endmodule

/* rtl/mfp_encode.sv */
// Input register and field encoder of the MSB-first field packer.
// Turns an input word into left-aligned stream bits. Depends on mfp_pkg.
module mfp_encode import mfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  output logic     enc_valid_o,
  input  logic     enc_ready_i,
  output enc_t     enc_o
);

  logic        in_vld_q;
  in_word_t    in_q;
  logic        enc_vld_q;
  enc_t        enc_q;
  enc_t        enc_d;
  logic        enc_load;
  logic        in_load;
  logic [6:0]  w;
  logic [6:0]  wm1;
  logic [63:0] uv;
  logic [63:0] mag;
  logic [63:0] low_mask;
  logic [63:0] top_bit;
  logic [63:0] enc_bits;
  logic        neg;

  assign enc_load   = !enc_vld_q || enc_ready_i;
  assign in_ready_o = !in_vld_q || enc_load;
  assign in_load    = in_ready_o;

  always_comb begin
    w        = (in_q.field_width > 7'd64) ? 7'd64 : in_q.field_width;
    wm1      = w - 7'd1;
    uv       = in_q.field_value;
    neg      = uv[63];
    mag      = neg ? (~uv + 64'd1) : uv;
    top_bit  = 64'd1 << wm1;
    low_mask = top_bit - 64'd1;
    enc_bits = '0;
    enc_d    = '0;
    unique case (in_q.func)
      FUNC_PLAIN: begin
        enc_bits = uv;
      end
      FUNC_SIGN_MAG: begin
        enc_bits = (mag & low_mask) | (neg ? top_bit : 64'd0);
      end
      FUNC_CHECKED: begin
        enc_d.err = (w != 7'd0) && (mag > low_mask);
        enc_bits  = enc_d.err ? top_bit : uv;
      end
      FUNC_FLUSH: begin
        enc_d.flush = 1'b1;
      end
      default: begin
        enc_bits = '0;
      end
    endcase
    enc_d.bits = enc_d.flush ? 64'd0 : (enc_bits << (7'd64 - w));
    enc_d.len  = enc_d.flush ? 7'd0 : w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      enc_vld_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_vld_q <= in_valid_i;
      end
      if (enc_load) begin
        enc_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      in_q <= in_word_i;
    end
    if (enc_load && in_vld_q) begin
      enc_q <= enc_d;
    end
  end

  assign enc_valid_o = enc_vld_q;
  assign enc_o       = enc_q;

endmodule

/* rtl/mfp_pack.sv */
// Packing state of the MSB-first field packer: partial byte, bit fill and
// stream byte counter. Merges encoded bits into a run of bytes. Uses mfp_pkg.
module mfp_pack import mfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  enc_t enc_i,
  output run_t run_o
);

  logic [7:0]       partial_q, partial_d;
  logic [2:0]       fill_q, fill_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [71:0]      stream;
  logic [71:0]      rest;
  logic [6:0]       total;
  logic [3:0]       nb;
  logic [CNT_W:0]   sum;

  always_comb begin
    stream = {partial_q, 64'd0} | ({enc_i.bits, 8'd0} >> fill_q);
    total  = {4'd0, fill_q} + enc_i.len;
    nb     = enc_i.flush ? {3'd0, fill_q != 3'd0} : total[6:3];
    rest   = stream << {nb, 3'd0};
    sum    = {1'b0, count_q} + (CNT_W + 1)'(nb);
    if (sum >= (CNT_W + 1)'(STREAM_BYTES)) begin
      sum = sum - (CNT_W + 1)'(STREAM_BYTES);
    end
    run_o.nbytes = nb;
    run_o.base   = count_q;
    run_o.err    = enc_i.err;
    if (enc_i.flush) begin
      run_o.bytes = {partial_q, 56'd0};
      partial_d   = 8'd0;
      fill_d      = 3'd0;
      count_d     = '0;
    end else begin
      run_o.bytes = stream[71:8];
      partial_d   = rest[71:64];
      fill_d      = total[2:0];
      count_d     = sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= 8'd0;
      fill_q    <= 3'd0;
      count_q   <= '0;
    end else if (load_i) begin
      partial_q <= partial_d;
      fill_q    <= fill_d;
      count_q   <= count_d;
    end
  end

endmodule

/* rtl/mfp_emit.sv */
// Result register of the MSB-first field packer. Holds one run of bytes and
// hands them out one word per cycle while out_stall_i is low. Uses mfp_pkg.
module mfp_emit import mfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      run_valid_i,
  output logic      run_ready_o,
  input  run_t      run_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic             vld_q;
  logic [63:0]      buf_q;
  logic [3:0]       rem_q;
  logic [CNT_W-1:0] off_q;
  logic             err_q;
  logic             take;
  logic             last;

  assign last        = (rem_q <= 4'd1);
  assign take        = vld_q && !out_stall_i;
  assign run_ready_o = !vld_q || (take && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (run_ready_o) begin
      vld_q <= run_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_ready_o) begin
      if (run_valid_i) begin
        buf_q <= run_i.bytes;
        rem_q <= run_i.nbytes;
        off_q <= run_i.base;
        err_q <= run_i.err;
      end
    end else if (take) begin
      buf_q <= {buf_q[55:0], 8'd0};
      rem_q <= rem_q - 4'd1;
      off_q <= (off_q == CNT_W'(STREAM_BYTES - 1)) ? '0 : off_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_word_o.byte_valid  = (rem_q != 4'd0);
    out_word_o.data_byte   = out_word_o.byte_valid ? buf_q[63:56] : 8'd0;
    out_word_o.byte_offset = out_word_o.byte_valid ? OFFSET_W'(off_q) : '0;
    out_word_o.range_error = err_q;
    out_word_o.last_of_run = last;
  end

  assign out_valid_o = vld_q;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for msb_first_field_packer_top: a queue-fed driver,
// a checking monitor and a bit-serial packing predictor.
// Depends on mfp_pkg and the packer RTL.
module tb import mfp_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  in_word_t  field_q[$];
  out_word_t due_words_q[$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bad_words = 0;
  int unsigned cycles = 0;

  logic [7:0]  pk_byte = '0;
  int unsigned pk_fill = 0;
  logic [9:0]  pk_count = '0;
  logic [7:0]  run_bytes[9];
  logic [9:0]  run_offs[9];
  int unsigned run_n;

  msb_first_field_packer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void close_byte();
    run_bytes[run_n] = pk_byte;
    run_offs[run_n]  = pk_count;
    run_n++;
    pk_count = pk_count + 10'd1;
    pk_byte  = '0;
    pk_fill  = 0;
  endfunction

  function automatic void shift_in(input logic [63:0] v, input int unsigned n);
    int i;
    for (i = int'(n) - 1; i >= 0; i--) begin
      pk_byte[7 - pk_fill] = v[i];
      pk_fill++;
      if (pk_fill == 8) close_byte();
    end
  endfunction

  function automatic void pack_field(input in_word_t w);
    int unsigned wd;
    logic [63:0] uv;
    logic [63:0] mag;
    logic [63:0] bound;
    logic        neg;
    logic        err;
    out_word_t   o;
    int unsigned k;
    wd = (w.field_width > 7'd64) ? 64 : w.field_width;
    uv = w.field_value;
    neg = uv[63];
    mag = neg ? -uv : uv;
    err = 1'b0;
    run_n = 0;
    case (w.func)
      FUNC_PLAIN: shift_in(uv, wd);
      FUNC_SIGN_MAG: begin
        if (wd > 0) begin
          shift_in({63'd0, neg}, 1);
          shift_in(mag, wd - 1);
        end
      end
      FUNC_CHECKED: begin
        if (wd > 0) begin
          bound = (wd == 1) ? 64'd0 : ({64{1'b1}} >> (65 - wd));
          if (mag > bound) begin
            err = 1'b1;
            shift_in(64'd1 << (wd - 1), wd);
          end else begin
            shift_in(uv, wd);
          end
        end
      end
      default: begin
        if (pk_fill != 0) close_byte();
        pk_byte  = '0;
        pk_fill  = 0;
        pk_count = '0;
      end
    endcase
    if (run_n == 0) begin
      o = '0;
      o.range_error = err;
      o.last_of_run = 1'b1;
      due_words_q.push_back(o);
    end else begin
      for (k = 0; k < run_n; k++) begin
        o = '0;
        o.data_byte   = run_bytes[k];
        o.byte_valid  = 1'b1;
        o.byte_offset = run_offs[k];
        o.range_error = err;
        o.last_of_run = (k == run_n - 1);
        due_words_q.push_back(o);
      end
    end
  endfunction

  function automatic in_word_t field_item(input mfp_func_e f, input int unsigned w,
                                          input logic [63:0] v);
    in_word_t it;
    it.func        = f;
    it.field_width = w[6:0];
    it.field_value = v;
    return it;
  endfunction

  function automatic in_word_t random_field(input bit with_flush);
    int unsigned r;
    int unsigned wd;
    int unsigned wc;
    logic [63:0] v;
    logic [63:0] bnd;
    mfp_func_e   f;
    r = $urandom_range(99);
    if (with_flush && r < 10) f = FUNC_FLUSH;
    else if (r < 45) f = FUNC_PLAIN;
    else if (r < 72) f = FUNC_SIGN_MAG;
    else f = FUNC_CHECKED;
    r = $urandom_range(99);
    if (r < 75) wd = $urandom_range(64, 48);
    else if (r < 90) wd = $urandom_range(127, 65);
    else if (r < 95) wd = $urandom_range(47, 1);
    else wd = 0;
    wc = (wd > 64) ? 64 : ((wd == 0) ? 1 : wd);
    bnd = (64'd1 << (wc - 1)) - 64'd1;
    v = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r >= 40 && r < 80) begin
      v = $signed(v << (64 - wc)) >>> (64 - wc);
    end else if (r >= 80) begin
      case ($urandom_range(7))
        0: v = 64'd0;
        1: v = {64{1'b1}};
        2: v = 64'h7FFF_FFFF_FFFF_FFFF;
        3: v = 64'h8000_0000_0000_0000;
        4: v = bnd;
        5: v = -bnd;
        6: v = bnd + 64'd1;
        default: v = -(bnd + 64'd1);
      endcase
    end
    return field_item(f, wd, v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      pk_byte    = '0;
      pk_fill    = 0;
      pk_count   = '0;
    end else begin
      if (in_valid_i && !in_stall_o) pack_field(in_word_i);
      if (!in_valid_i || !in_stall_o) begin
        if (field_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_word_i  <= field_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : mon
    out_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_words_q.size() == 0) begin
          if (bad_words < 10)
            $display("unexpected word: data %h valid %b offset %0d err %b last %b",
                     out_word_o.data_byte, out_word_o.byte_valid,
                     out_word_o.byte_offset, out_word_o.range_error,
                     out_word_o.last_of_run);
          bad_words++;
        end else begin
          want = due_words_q.pop_front();
          if (out_word_o.data_byte !== want.data_byte ||
              out_word_o.byte_valid !== want.byte_valid ||
              out_word_o.byte_offset !== want.byte_offset ||
              out_word_o.range_error !== want.range_error ||
              out_word_o.last_of_run !== want.last_of_run) begin
            if (bad_words < 10)
              $display("word mismatch: got data %h valid %b offset %0d err %b last %b,%s",
                       out_word_o.data_byte, out_word_o.byte_valid,
                       out_word_o.byte_offset, out_word_o.range_error,
                       out_word_o.last_of_run, " expected:");
            if (bad_words < 10)
              $display("  data %h valid %b offset %0d err %b last %b",
                       want.data_byte, want.byte_valid, want.byte_offset,
                       want.range_error, want.last_of_run);
            bad_words++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("msb_first_field_packer_top test failed");
    $finish;
  end

  task automatic drain();
    while (field_q.size() != 0 || in_valid_i || due_words_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned count, input bit with_flush);
    int unsigned i;
    @(negedge clk_i);
    idle_pct  = idle;
    stall_pct = stall;
    for (i = 0; i < count; i++) field_q.push_back(random_field(with_flush));
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    field_q.push_back(field_item(FUNC_PLAIN, 1, 64'd1));
    field_q.push_back(field_item(FUNC_PLAIN, 0, 64'hFF));
    field_q.push_back(field_item(FUNC_PLAIN, 64, {64{1'b1}}));
    field_q.push_back(field_item(FUNC_PLAIN, 127, 64'h0123_4567_89AB_CDEF));
    field_q.push_back(field_item(FUNC_PLAIN, 7, 64'h55));
    field_q.push_back(field_item(FUNC_SIGN_MAG, 1, -64'd3));
    field_q.push_back(field_item(FUNC_SIGN_MAG, 8, -64'd5));
    field_q.push_back(field_item(FUNC_SIGN_MAG, 64, 64'h8000_0000_0000_0000));
    field_q.push_back(field_item(FUNC_SIGN_MAG, 0, {64{1'b1}}));
    field_q.push_back(field_item(FUNC_SIGN_MAG, 64, 64'h7FFF_FFFF_FFFF_FFFF));
    field_q.push_back(field_item(FUNC_CHECKED, 1, 64'd0));
    field_q.push_back(field_item(FUNC_CHECKED, 1, 64'd1));
    field_q.push_back(field_item(FUNC_CHECKED, 1, {64{1'b1}}));
    field_q.push_back(field_item(FUNC_CHECKED, 8, 64'd127));
    field_q.push_back(field_item(FUNC_CHECKED, 8, 64'd128));
    field_q.push_back(field_item(FUNC_CHECKED, 8, -64'd127));
    field_q.push_back(field_item(FUNC_CHECKED, 8, -64'd128));
    field_q.push_back(field_item(FUNC_CHECKED, 64, 64'h7FFF_FFFF_FFFF_FFFF));
    field_q.push_back(field_item(FUNC_CHECKED, 64, 64'h8000_0000_0000_0000));
    field_q.push_back(field_item(FUNC_CHECKED, 0, 64'd5));
    field_q.push_back(field_item(FUNC_FLUSH, 0, 64'd0));
    field_q.push_back(field_item(FUNC_PLAIN, 3, 64'd5));
    field_q.push_back(field_item(FUNC_FLUSH, 0, 64'd0));
    field_q.push_back(field_item(FUNC_FLUSH, 127, {64{1'b1}}));
    drain();
    run_phase(0, 0, 76, 1'b0);
    run_phase(80, 0, 40, 1'b0);
    run_phase(0, 80, 40, 1'b0);
    run_phase(16, 16, 30, 1'b1);
    repeat (20) @(negedge clk_i);
    if (bad_words == 0 && due_words_q.size() == 0) begin
      $display("msb_first_field_packer_top test passed");
    end else begin
      $display("msb_first_field_packer_top test failed");
    end
    $finish;
  end

endmodule
